>>> sv/udvc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the tanh table builder for the velocity compensator.
package udvc_pkg;

  localparam int AXES      = 4;
  localparam int DATA_W    = 16;
  localparam int REF_W     = 24;
  localparam int ARG_W     = 19;
  localparam int TH_W      = 13;
  localparam int CTRL_W    = 28;
  localparam int SUM_W     = 41;
  localparam int Q_FRAC    = 12;
  localparam int TANH_ONE  = 4096;
  localparam int TANH_ARG_SHIFT = 14;

  localparam int TANH_DEPTH_MAX           = 4096;
  localparam int TANH_TABLE_DEPTH_DEFAULT = 256;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_HZ   = 2'd2;

  // Command source codes
  localparam logic [1:0] MODE_MANUAL    = 2'd0;
  localparam logic [1:0] MODE_KINEMATIC = 2'd1;
  localparam logic [1:0] MODE_VISUAL    = 2'd2;

  // Diagonal inertia and damping, Q.12
  localparam int INERTIA_Q12 [AXES] = '{1335, 1551, 1697, 940};
  localparam int DAMPING_Q12 [AXES] = '{3122, 3391, 3456, 4256};

  typedef struct packed {
    logic [14:0] sat_level;
    logic [14:0] slope;
    logic [9:0]  rate_hz;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef logic [TANH_DEPTH_MAX-1:0][TH_W-1:0] tanh_rom_t;

  // Long division of nonnegative values; evaluated only while the table is built
  function automatic longint udiv(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'sd1;
      end
    end
    return quo;
  endfunction

  // Build tanh(4*i/depth) in Q.12 from exp(-2x) in Q30 by repeated multiplication
  function automatic tanh_rom_t build_tanh_rom(input longint step, input int depth);
    longint    one;
    longint    q;
    longint    term;
    longint    t;
    longint    num;
    longint    den;
    tanh_rom_t rom;
    one  = 64'sd1 <<< 30;
    q    = one;
    term = one;
    t    = one;
    rom  = '0;
    for (int k = 1; k <= 10; k++) begin
      term = udiv((term * step) >>> 30, longint'(k));
      q    = k[0] ? (q - term) : (q + term);
    end
    for (int i = 0; i < TANH_DEPTH_MAX; i++) begin
      if (i < depth) begin
        num    = (one - t) * 8192 + (one + t);
        den    = 2 * (one + t);
        rom[i] = TH_W'(udiv(num, den));
        t      = (t * q + (one >>> 1)) >>> 30;
      end
    end
    return rom;
  endfunction

endpackage

>>> sv/udvc_lane.sv
`timescale 1ns / 1ps
// One axis lane: rate term, tanh gain term and inertia/damping model, six register stages.
module udvc_lane
  import udvc_pkg::*;
#(
  parameter int TANH_TABLE_DEPTH = TANH_TABLE_DEPTH_DEFAULT,
  parameter int AXIS             = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic signed [DATA_W-1:0] vc,
  input  logic signed [DATA_W-1:0] meas,
  input  logic                     commit,
  output logic signed [SUM_W-1:0]  sum
);

  localparam longint    TanhStep  = (64'sd8 <<< 30) / TANH_TABLE_DEPTH;
  localparam tanh_rom_t TanhFull  = build_tanh_rom(TanhStep, TANH_TABLE_DEPTH);
  localparam int        DepthW    = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int        IdxW      = $clog2(TANH_TABLE_DEPTH);
  localparam int        ProdW     = ARG_W + DepthW;
  localparam int        IdxFullW  = ProdW - TANH_ARG_SHIFT;

  logic [TH_W-1:0] rom [TANH_TABLE_DEPTH];

  logic signed [DATA_W-1:0] prev;
  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W:0]   err;
  logic [DATA_W-1:0]        mag;
  logic                     neg1;
  logic signed [CTRL_W-1:0] rate2;
  logic [ARG_W-1:0]         arg;
  logic                     neg2;
  logic signed [CTRL_W-1:0] rate3;
  logic [IdxFullW-1:0]      idx_full;
  logic                     neg3;
  logic signed [CTRL_W-1:0] rate4;
  logic [TH_W-1:0]          th;
  logic                     neg4;
  logic signed [CTRL_W-1:0] control;

  logic [31:0]              arg_prod;
  logic [ProdW-1:0]         idx_prod;
  logic [27:0]              g_prod;
  logic signed [DATA_W:0]   g_pos;
  logic signed [DATA_W:0]   g_sel;

  // Constant tanh table for this depth
  for (genvar i = 0; i < TANH_TABLE_DEPTH; i++) begin : g_rom
    assign rom[i] = TanhFull[i];
  end

  // Hold the previous command; advance it when the item finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (commit) begin
      prev <= vc;
    end
  end

  assign err      = (DATA_W+1)'(vc) - (DATA_W+1)'(meas);
  assign arg_prod = 32'(cfg.slope) * 32'(mag);
  assign idx_prod = ProdW'(arg) * ProdW'(TANH_TABLE_DEPTH);
  assign g_prod   = 28'(cfg.sat_level) * 28'(th);
  assign g_pos    = $signed({1'b0, g_prod[27:Q_FRAC]});
  assign g_sel    = neg4 ? -g_pos : g_pos;

  // Free-running stages; the sequencer samples the last one at the right step
  always_ff @(posedge clk) begin
    // command difference and error magnitude
    diff  <= (DATA_W+1)'(vc) - (DATA_W+1)'(prev);
    mag   <= err[DATA_W] ? DATA_W'(-err) : DATA_W'(err);
    neg1  <= err[DATA_W];
    // rate term and tanh argument
    rate2 <= CTRL_W'(diff) * CTRL_W'($signed({1'b0, cfg.rate_hz}));
    arg   <= ARG_W'(arg_prod >> Q_FRAC);
    neg2  <= neg1;
    // table index
    rate3    <= rate2;
    idx_full <= IdxFullW'(idx_prod >> TANH_ARG_SHIFT);
    neg3     <= neg2;
    // table lookup, saturate past the end
    rate4 <= rate3;
    th    <= (idx_full >= IdxFullW'(TANH_TABLE_DEPTH)) ? TH_W'(TANH_ONE)
                                                      : rom[idx_full[IdxW-1:0]];
    neg4  <= neg3;
    // scaled gain plus rate term
    control <= rate4 + CTRL_W'(g_sel);
    // inertia and damping model
    sum <= SUM_W'(control) * SUM_W'(INERTIA_Q12[AXIS])
         + SUM_W'(vc) * SUM_W'(DAMPING_Q12[AXIS]);
  end

endmodule

>>> sv/udvc_merge.sv
`timescale 1ns / 1ps
// Merge stage: round and saturate the lane sums into the output register.
module udvc_merge
  import udvc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic signed [SUM_W-1:0] sum [AXES],
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [REF_W-1:0] ref_out [AXES]
);

  localparam int RndW = SUM_W - Q_FRAC;
  localparam logic signed [RndW-1:0] RefMax = RndW'((64'sd1 <<< (REF_W - 1)) - 1);
  localparam logic signed [RndW-1:0] RefMin = -RndW'(64'sd1 <<< (REF_W - 1));

  logic signed [RndW-1:0]  rnd [AXES];
  logic signed [REF_W-1:0] sat [AXES];

  // Round half up to Q.12, then clamp to the output range
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      rnd[a] = RndW'((sum[a] + SUM_W'(1 <<< (Q_FRAC - 1))) >>> Q_FRAC);
      if (rnd[a] > RefMax) begin
        sat[a] = REF_W'(RefMax);
      end else if (rnd[a] < RefMin) begin
        sat[a] = REF_W'(RefMin);
      end else begin
        sat[a] = REF_W'(rnd[a]);
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ref_out <= sat;
    end
  end

endmodule

>>> sv/uav_dynamic_velocity_compensator_core.sv
`timescale 1ns / 1ps
// Velocity compensator usage notes:
// Input channel (in_valid/in_ready) takes one control tick: mode, four stick
// axes, three vision velocities and four measured velocities, all Q4.12.
// Output channel (out_valid/out_ready) gives the four compensated references,
// Q12.12, rounded and saturated. One result per item.
// Configuration: write cfg_we with cfg_index 0 (sat_level), 1 (slope) or
// 2 (rate_hz) and cfg_data; write only while no item is in flight.
// Four lanes, one per axis, run a six-stage chain (difference and magnitude,
// rate term and tanh argument, table index, table lookup, gain,
// inertia/damping), and a merge stage rounds and registers the results.
// One item is in flight at a time: in_ready returns with out_valid, at the
// edge that registers the result, so the next item waits for that edge.
// The output register frees the input side: a new item is accepted while a
// result waits. If the receiver still holds the previous result when the
// next one is ready, the sequencer holds at its last step and waits for out_ready.
// Reset returns the registers to sat_level 0.5, slope 1.0, rate 30 Hz and
// clears the previous command.
module uav_dynamic_velocity_compensator_core
  import udvc_pkg::*;
#(
  parameter int TANH_TABLE_DEPTH = TANH_TABLE_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                mode,
  input  logic signed [DATA_W-1:0]  stick_a0,
  input  logic signed [DATA_W-1:0]  stick_a1,
  input  logic signed [DATA_W-1:0]  stick_a2,
  input  logic signed [DATA_W-1:0]  stick_a3,
  input  logic signed [DATA_W-1:0]  vision_vx,
  input  logic signed [DATA_W-1:0]  vision_vy,
  input  logic signed [DATA_W-1:0]  vision_wz,
  input  logic signed [DATA_W-1:0]  meas_vx,
  input  logic signed [DATA_W-1:0]  meas_vy,
  input  logic signed [DATA_W-1:0]  meas_vz,
  input  logic signed [DATA_W-1:0]  meas_wz,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [REF_W-1:0]   ref_vx,
  output logic signed [REF_W-1:0]   ref_vy,
  output logic signed [REF_W-1:0]   ref_vz,
  output logic signed [REF_W-1:0]   ref_wz
);

  localparam logic [2:0] LastStep = 3'd6;

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  logic [2:0] cnt;
  logic [2:0] cnt_next;
  logic       accept;
  logic       out_free;
  logic       finish;

  logic signed [DATA_W-1:0] vc       [AXES];
  logic signed [DATA_W-1:0] vc_next  [AXES];
  logic signed [DATA_W-1:0] meas     [AXES];
  logic signed [SUM_W-1:0]  lane_sum [AXES];
  logic signed [REF_W-1:0]  ref_out  [AXES];

  function automatic logic signed [DATA_W-1:0] neg_sat(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] min_v;
    min_v = {1'b1, {(DATA_W-1){1'b0}}};
    return (v == min_v) ? ~min_v : -v;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sat_level <= 15'd2048;
      cfg.slope     <= 15'd4096;
      cfg.rate_hz   <= 10'd30;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAT_LEVEL: cfg.sat_level <= cfg_data;
        CFG_SLOPE:     cfg.slope     <= cfg_data;
        CFG_RATE_HZ:   cfg.rate_hz   <= cfg_data[9:0];
        default:       ;
      endcase
    end
  end

  // Pick the commanded velocity from the mode
  always_comb begin
    case (mode)
      MODE_KINEMATIC: begin
        vc_next[0] = stick_a1;
        vc_next[1] = neg_sat(stick_a0);
        vc_next[2] = stick_a3;
        vc_next[3] = neg_sat(stick_a2);
      end
      MODE_VISUAL: begin
        vc_next[0] = vision_vx;
        vc_next[1] = vision_vy;
        vc_next[2] = stick_a3 >>> 2;
        vc_next[3] = vision_wz;
      end
      default: begin
        for (int a = 0; a < AXES; a++) begin
          vc_next[a] = '0;
        end
      end
    endcase
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      vc      <= vc_next;
      meas[0] <= meas_vx;
      meas[1] <= meas_vy;
      meas[2] <= meas_vz;
      meas[3] <= meas_wz;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_RUN;
          cnt_next   = '0;
        end
      end
      ST_RUN: begin
        if (cnt != LastStep) begin
          cnt_next = cnt + 3'd1;
        end else if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // One lane per axis
  for (genvar a = 0; a < AXES; a++) begin : g_lane
    udvc_lane #(
      .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH),
      .AXIS            (a)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .cfg   (cfg),
      .vc    (vc[a]),
      .meas  (meas[a]),
      .commit(finish),
      .sum   (lane_sum[a])
    );
  end

  udvc_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (finish),
    .sum      (lane_sum),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .ref_out  (ref_out)
  );

  assign ref_vx = ref_out[0];
  assign ref_vy = ref_out[1];
  assign ref_vz = ref_out[2];
  assign ref_wz = ref_out[3];

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    finish |-> (!out_valid || out_ready))
    else $error("result loaded over a pending item");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RUN && cnt == '0 && !in_ready))
    else $error("accepted item did not start the lanes");

  a_valid_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_RUN && $past(cnt) == LastStep))
    else $error("result appeared without a finished item");

  a_run_length: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##7 (state == ST_RUN || $past(finish)))
    else $error("item finished early");
`endif

endmodule
